>>> src/vmap_pkg.sv
`timescale 1ns / 1ps
// Package for the video memory access port: operation codes, store geometry,
// the request struct passed to the store and the address mirroring function. No dependencies.
package vmap_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        OP_SCROLL_WR = 3'd0,
        OP_ADDR_WR   = 3'd1,
        OP_DATA_WR   = 3'd2,
        OP_DATA_RD   = 3'd3,
        OP_PALETTE   = 3'd4
    } op_t;

    // what the output stage makes of the store read data
    typedef enum logic [1:0] {
        RD_NONE,
        RD_DATA,
        RD_PAL
    } rd_sel_t;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } vmap_req_t;

    localparam logic [13:0] NT_MIRROR_LO  = 14'h3000;
    localparam logic [13:0] NT_MIRROR_HI  = 14'h3F00;
    localparam logic [13:0] NT_MIRROR_OFS = 14'h1000;
    localparam logic [13:0] PAL_END       = 14'h3F20;
    localparam logic [13:0] PAL_SPR       = 14'h3F10;
    localparam logic [13:0] PAL_SPR_OFS   = 14'h0010;

    // Map a 16-bit video address onto the store.
    function automatic logic [STORE_AW-1:0] map_address(input logic [15:0] addr_in);
        logic [13:0] a;
        logic [13:0] result;
        a = addr_in[13:0];
        if (a >= NT_MIRROR_LO && a < NT_MIRROR_HI) begin
            result = a - NT_MIRROR_OFS;
        end else begin
            if (a >= PAL_END) begin
                a = {a[13:8], 3'b000, a[4:0]};
            end
            if (a >= PAL_SPR && a < PAL_END && a[1:0] == 2'b00) begin
                a = a - PAL_SPR_OFS;
            end
            result = a;
        end
        return result[STORE_AW-1:0];
    endfunction

endpackage

>>> src/video_memory_access_port.sv
`timescale 1ns / 1ps
// Top level of the video memory access port: stream ports, result staging and
// output register. Depends on vmap_pkg, vmap_regs and vmap_store.
//
// After reset the block clears its 16384-byte video store, one byte a cycle, and
// accepts no access until the sweep is done; configuration writes are taken at any
// time. It then takes one access per cycle while the output is not stalled: the store
// read issued at acceptance completes in the next cycle, and the result moves on to the
// output register once that is free. A stalled output holds back the input once the
// one staging slot is full.
module video_memory_access_port (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: bit 0 = increment_by_32
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] write_value, [23:8] palette_base, [31:24] color_index
    input  logic [31:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [23:8] scroll_word, [39:24] pointer_now
    output logic [39:0] m_tdata
);

    logic inc32_reg;

    logic                init_done;
    logic                accept;
    logic                out_free;
    logic                move;
    vmap_pkg::vmap_req_t req;
    vmap_pkg::rd_sel_t   rd_sel;
    logic [15:0]         scroll_after;
    logic [15:0]         pointer_after;
    logic [7:0]          rdata;

    logic              stage_valid_reg, stage_valid_next;
    vmap_pkg::rd_sel_t stage_sel_reg;
    logic [15:0]       stage_scroll_reg;
    logic [15:0]       stage_ptr_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_rd_reg;
    logic [15:0] out_scroll_reg;
    logic [15:0] out_ptr_reg;
    logic [7:0]  rd_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc32_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            inc32_reg <= cfg_data[0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign move     = stage_valid_reg && out_free;
    assign s_tready = init_done && (!stage_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    vmap_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .operation       (s_tuser),
        .write_value     (s_tdata[7:0]),
        .palette_base    (s_tdata[23:8]),
        .color_index     (s_tdata[31:24]),
        .increment_by_32 (inc32_reg),
        .req             (req),
        .rd_sel          (rd_sel),
        .scroll_after    (scroll_after),
        .pointer_after   (pointer_after)
    );

    vmap_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rdata     (rdata),
        .init_done (init_done)
    );

    always_comb begin
        stage_valid_next = accept || (stage_valid_reg && !move);
        out_valid_next   = move || (out_valid_reg && !m_tready);
        unique case (stage_sel_reg)
            vmap_pkg::RD_DATA: rd_value = rdata;
            vmap_pkg::RD_PAL:  rd_value = {2'b00, rdata[5:0]};
            default:           rd_value = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // hold the staged result until the output register frees up
    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_sel_reg    <= rd_sel;
            stage_scroll_reg <= scroll_after;
            stage_ptr_reg    <= pointer_after;
        end
        if (move) begin
            out_rd_reg     <= rd_value;
            out_scroll_reg <= stage_scroll_reg;
            out_ptr_reg    <= stage_ptr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ptr_reg, out_scroll_reg, out_rd_reg};

    a_no_accept_during_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> init_done)
        else $error("access accepted while the store is still being cleared");

    a_accept_fills_stage : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> stage_valid_reg)
        else $error("accepted access did not reach the staging slot");

    a_stage_held_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && out_valid_reg && !m_tready |=> stage_valid_reg)
        else $error("staged result dropped while the output was stalled");

    a_move_fills_output : assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> out_valid_reg)
        else $error("staged result did not reach the output register");

endmodule

>>> src/vmap_store.sv
`timescale 1ns / 1ps
// Video store: 16 KiB single-write, single-read synchronous RAM with a clearing
// sweep after reset. Depends on vmap_pkg.
module vmap_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  vmap_pkg::vmap_req_t req,
    output logic [7:0]         rdata,
    output logic               init_done
);

    logic [7:0] mem [vmap_pkg::STORE_DEPTH];

    logic [vmap_pkg::STORE_AW-1:0] clr_addr_reg;
    logic [vmap_pkg::STORE_AW-1:0] clr_addr_next;
    logic                          done_reg;
    logic                          done_next;
    logic [7:0]                    rdata_reg;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        done_next     = done_reg;
        if (!done_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    // clearing sweep owns the write port until it finishes
    always_ff @(posedge aclk) begin
        if (!done_reg) begin
            mem[clr_addr_reg] <= 8'h00;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata     = rdata_reg;
    assign init_done = done_reg;

endmodule

>>> src/vmap_regs.sv
`timescale 1ns / 1ps
// Access registers: scroll and address write latches, the memory pointer and the
// store request for each accepted access. Depends on vmap_pkg.
module vmap_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [2:0]          operation,
    input  logic [7:0]          write_value,
    input  logic [15:0]         palette_base,
    input  logic [7:0]          color_index,
    input  logic                increment_by_32,
    output vmap_pkg::vmap_req_t req,
    output vmap_pkg::rd_sel_t   rd_sel,
    output logic [15:0]         scroll_after,
    output logic [15:0]         pointer_after
);

    logic [15:0] pointer_reg,      pointer_next;
    logic [15:0] scroll_reg,       scroll_next;
    logic        scroll_half_reg,  scroll_half_next;
    logic [7:0]  scroll_hi_reg,    scroll_hi_next;
    logic        pointer_half_reg, pointer_half_next;
    logic [7:0]  pointer_hi_reg,   pointer_hi_next;

    logic [15:0] step;
    logic [7:0]  pal_idx;
    logic [15:0] pal_addr;

    always_comb begin
        step     = increment_by_32 ? 16'd32 : 16'd1;
        pal_idx  = (color_index[1:0] == 2'b00) ? 8'h00 : color_index;
        pal_addr = palette_base + {8'h00, pal_idx};

        pointer_next      = pointer_reg;
        scroll_next       = scroll_reg;
        scroll_half_next  = scroll_half_reg;
        scroll_hi_next    = scroll_hi_reg;
        pointer_half_next = pointer_half_reg;
        pointer_hi_next   = pointer_hi_reg;
        req.wr_en         = 1'b0;
        req.rd_en         = 1'b0;
        req.addr          = vmap_pkg::map_address(pointer_reg);
        req.wdata         = write_value;
        rd_sel            = vmap_pkg::RD_NONE;

        if (accept) begin
            unique case (operation)
                vmap_pkg::OP_SCROLL_WR: begin
                    if (scroll_half_reg) begin
                        scroll_next      = {scroll_hi_reg, write_value};
                        scroll_half_next = 1'b0;
                    end else begin
                        scroll_hi_next   = write_value;
                        scroll_half_next = 1'b1;
                    end
                end
                vmap_pkg::OP_ADDR_WR: begin
                    if (pointer_half_reg) begin
                        pointer_next      = {pointer_hi_reg, write_value};
                        pointer_half_next = 1'b0;
                    end else begin
                        pointer_hi_next   = write_value;
                        pointer_half_next = 1'b1;
                    end
                end
                vmap_pkg::OP_DATA_WR: begin
                    req.wr_en    = 1'b1;
                    pointer_next = pointer_reg + step;
                end
                vmap_pkg::OP_DATA_RD: begin
                    req.rd_en    = 1'b1;
                    rd_sel       = vmap_pkg::RD_DATA;
                    pointer_next = pointer_reg + step;
                end
                vmap_pkg::OP_PALETTE: begin
                    req.rd_en = 1'b1;
                    req.addr  = vmap_pkg::map_address(pal_addr);
                    rd_sel    = vmap_pkg::RD_PAL;
                end
                default: begin
                    // unused codes leave everything alone
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pointer_reg      <= '0;
            scroll_reg       <= '0;
            scroll_half_reg  <= 1'b0;
            scroll_hi_reg    <= '0;
            pointer_half_reg <= 1'b0;
            pointer_hi_reg   <= '0;
        end else begin
            pointer_reg      <= pointer_next;
            scroll_reg       <= scroll_next;
            scroll_half_reg  <= scroll_half_next;
            scroll_hi_reg    <= scroll_hi_next;
            pointer_half_reg <= pointer_half_next;
            pointer_hi_reg   <= pointer_hi_next;
        end
    end

    assign scroll_after  = scroll_next;
    assign pointer_after = pointer_next;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for video_memory_access_port: directed and random accesses checked against
// a cycle-free model of the pointer, latches and mirrored store. Depends on vmap_pkg and video_memory_access_port.
module tb;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] scroll_word;
        logic [15:0] pointer_now;
    } port_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] write_value, [23:8] palette_base, [31:24] color_index
    logic [31:0] s_tdata = '0;
    // [2:0] operation
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] read_data, [23:8] scroll_word, [39:24] pointer_now
    logic [39:0] m_tdata;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // model state
    logic [7:0]  vram_model [0:vmap_pkg::STORE_DEPTH-1];
    logic [15:0] vram_ptr;
    logic [15:0] scroll_reg;
    logic        scroll_half;
    logic [7:0]  scroll_hi;
    logic        ptr_half;
    logic [7:0]  ptr_hi;
    logic        step_32;

    port_result_t pending_results [$];
    int           mismatches = 0;
    int           accesses_sent = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_stall_on = 1'b1;

    video_memory_access_port uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Fold a 16-bit video address onto the 16 KiB store.
    function automatic logic [13:0] mirror_addr(input logic [15:0] addr);
        logic [13:0] a;
        a = addr[13:0];
        if (a >= 14'h3000 && a < 14'h3F00) begin
            return a - 14'h1000;
        end
        // palette page: only 32 entries, backdrop slots of the sprite half alias the first half
        if (a[13:8] == 6'h3F) begin
            a[7:5] = 3'b000;
            if (a[4] && a[1:0] == 2'b00) begin
                a[4] = 1'b0;
            end
        end
        return a;
    endfunction

    function automatic port_result_t apply_access(input logic [2:0] op, input logic [7:0] val,
                                                  input logic [15:0] base, input logic [7:0] idx);
        port_result_t r;
        logic [7:0]   colour;
        logic [15:0]  step;
        r.read_data = 8'h00;
        step = step_32 ? 16'd32 : 16'd1;
        case (op)
            vmap_pkg::OP_SCROLL_WR: begin
                if (scroll_half) begin
                    scroll_reg = {scroll_hi, val};
                end else begin
                    scroll_hi = val;
                end
                scroll_half = ~scroll_half;
            end
            vmap_pkg::OP_ADDR_WR: begin
                if (ptr_half) begin
                    vram_ptr = {ptr_hi, val};
                end else begin
                    ptr_hi = val;
                end
                ptr_half = ~ptr_half;
            end
            vmap_pkg::OP_DATA_WR: begin
                vram_model[mirror_addr(vram_ptr)] = val;
                vram_ptr = vram_ptr + step;
            end
            vmap_pkg::OP_DATA_RD: begin
                r.read_data = vram_model[mirror_addr(vram_ptr)];
                vram_ptr = vram_ptr + step;
            end
            vmap_pkg::OP_PALETTE: begin
                colour = (idx[1:0] == 2'b00) ? 8'h00 : idx;
                r.read_data = {2'b00, vram_model[mirror_addr(base + {8'h00, colour})][5:0]};
            end
            default: begin
            end
        endcase
        r.scroll_word = scroll_reg;
        r.pointer_now = vram_ptr;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input port_result_t want,
                                   input port_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected rd=%02h scroll=%04h ptr=%04h,",
                     $time, what, want.read_data, want.scroll_word, want.pointer_now,
                     " got rd=%02h scroll=%04h ptr=%04h",
                     got.read_data, got.scroll_word, got.pointer_now);
        end
    endtask

    always @(posedge aclk) begin : check_results
        port_result_t got;
        port_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.read_data   = m_tdata[7:0];
            got.scroll_word = m_tdata[23:8];
            got.pointer_now = m_tdata[39:24];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Result side back-pressure.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (1 + idle_len()) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at a falling edge with the transfer done.
    task automatic send_access(input logic [2:0] op, input logic [7:0] val,
                               input logic [15:0] base, input logic [7:0] idx);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {idx, base, val};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_results.push_back(apply_access(op, val, base, idx));
        accesses_sent++;
        @(negedge aclk);
        gap = tx_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic scroll_write(input logic [7:0] v);
        send_access(vmap_pkg::OP_SCROLL_WR, v, 16'($urandom), 8'($urandom));
    endtask

    task automatic addr_write(input logic [7:0] v);
        send_access(vmap_pkg::OP_ADDR_WR, v, 16'($urandom), 8'($urandom));
    endtask

    task automatic data_write(input logic [7:0] v);
        send_access(vmap_pkg::OP_DATA_WR, v, 16'($urandom), 8'($urandom));
    endtask

    task automatic data_read();
        send_access(vmap_pkg::OP_DATA_RD, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic palette_lookup(input logic [15:0] base, input logic [7:0] idx);
        send_access(vmap_pkg::OP_PALETTE, 8'($urandom), base, idx);
    endtask

    // Complete a half-written latch first so the pair lands as intended.
    task automatic set_pointer(input logic [15:0] addr);
        if (ptr_half) addr_write(8'($urandom));
        addr_write(addr[15:8]);
        addr_write(addr[7:0]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_step_32(input logic v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        step_32 = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        data_read();
        palette_lookup(16'h0000, 8'h00);
        send_access(OP_UNUSED_LAST, 8'hFF, 16'hFFFF, 8'hFF);
    endtask

    // Interleave the two latches so neither disturbs the other.
    task automatic test_latches();
        addr_write(8'hFF);
        scroll_write(8'hFF);
        scroll_write(8'h00);
        addr_write(8'hFF);
        scroll_write(8'h00);
        scroll_write(8'hFF);
    endtask

    task automatic test_mirroring();
        // top of the 16-bit space lands in the palette page, pointer wraps to zero
        data_write(8'hFF);
        palette_lookup(16'h3F00, 8'h1F);
        set_pointer(16'h3F10);
        data_write(8'hC3);
        palette_lookup(16'hFF00, 8'h08);
        set_pointer(16'h3005);
        data_write(8'h5A);
        set_pointer(16'h2005);
        data_read();
        send_access(OP_UNUSED_FIRST, 8'h00, 16'h0000, 8'h00);
        send_access(OP_UNUSED_MID, 8'hAA, 16'h5555, 8'h55);
    endtask

    task automatic test_step_32();
        write_step_32(1'b1);
        set_pointer(16'hFFF0);
        data_write(8'h81);
        data_read();
    endtask

    function automatic logic [15:0] pick_region_addr();
        logic [13:0] a;
        case ($urandom_range(0, 4))
            0: a = 14'($urandom_range(16'h0000, 16'h1FFF));
            1: a = 14'($urandom_range(16'h2000, 16'h2FFF));
            2: a = 14'($urandom_range(16'h3000, 16'h3EFF));
            3: a = 14'($urandom_range(16'h3F00, 16'h3FFF));
            default: a = 14'($urandom);
        endcase
        return {2'($urandom_range(0, 3)), a};
    endfunction

    // Write a run of bytes, then read them back through an alias of the start address.
    task automatic burst_roundtrip();
        logic [15:0] start;
        logic [15:0] again;
        int          n;
        start = pick_region_addr();
        n = $urandom_range(1, 12);
        set_pointer(start);
        repeat (n) begin
            data_write(8'($urandom));
            if ($urandom_range(0, 9) == 0) scroll_write(8'($urandom));
        end
        again = {2'($urandom_range(0, 3)), start[13:0]};
        if (again[13:12] == 2'b10 && again[11:8] != 4'hF && $urandom_range(0, 1) == 1) begin
            again = again + 16'h1000;
        end
        set_pointer(again);
        repeat (n) begin
            data_read();
            if ($urandom_range(0, 9) == 0) palette_lookup(16'($urandom), 8'($urandom));
        end
    endtask

    task automatic palette_scan();
        logic [15:0] base;
        base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {2'($urandom_range(0, 3)), 14'h3F00};
        repeat ($urandom_range(1, 8)) palette_lookup(base, 8'($urandom));
    endtask

    task automatic random_noise();
        int unsigned r;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 19);
            send_access((r < 19) ? 3'(r % 5) : 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                        8'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int quota);
        int target;
        int next_mix;
        int unsigned r;
        target = accesses_sent + quota;
        next_mix = accesses_sent;
        while (accesses_sent < target) begin
            if (accesses_sent >= next_mix) begin
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
                next_mix = accesses_sent + 100;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                burst_roundtrip();
            end else if (r < 60) begin
                palette_scan();
            end else if (r < 70) begin
                if (scroll_half) scroll_write(8'($urandom));
                scroll_write(8'($urandom));
                scroll_write(8'($urandom));
            end else begin
                random_noise();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < vmap_pkg::STORE_DEPTH; i++) vram_model[i] = 8'h00;
        vram_ptr    = '0;
        scroll_reg  = '0;
        scroll_half = 1'b0;
        scroll_hi   = '0;
        ptr_half    = 1'b0;
        ptr_hi      = '0;
        step_32     = 1'b0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_step_32(1'b0);
        test_reset_state();
        test_latches();
        test_mirroring();
        test_step_32();
        for (int phase = 0; phase < 4; phase++) begin
            write_step_32(phase[0]);
            test_random_traffic(440);
        end
        write_step_32(1'b1);
        test_random_traffic(50);

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
